FILE: sv/pdq_pkg.sv
// ----------------------------------------------------------------------------
// Point deque package
// Field widths, action codes and status codes shared by the deque core, its
// checker and its testbench.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int PDQ_DEPTH = 64;
  localparam int COORD_W   = 32;
  localparam int POINT_W   = 2 * COORD_W;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_READ_FWD   = 3'd5,
    ACT_READ_BWD   = 3'd6
  } action_e;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

FILE: sv/point_deque_core.sv
// ----------------------------------------------------------------------------
// Point deque core
// Bounded double-ended queue of (x, y) points held in a synchronous ring
// memory, with push, pop, clear and full read-out in either direction.
// ----------------------------------------------------------------------------
// A push, a refused push, a clear or any empty-store result reaches the output
// register in the cycle after its transfer. A pop first reads the point from
// the ring memory, whose read is registered, and then loads it into the output
// register. A read steps through an issue state and a load state for each
// stored point, waiting in the issue state while the output register is
// blocked: each point is one memory read followed by one output register
// load. A new input transfer is taken when the core is idle and its output
// register is empty or being emptied in the same cycle. The memory holds no
// reset value, so no clearing pass is needed after reset.
module point_deque_core
  import pdq_pkg::*;
#(
  parameter int DEPTH = PDQ_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [POINT_W-1:0]   s_axis_tdata,   // point_x, point_y
  input  logic [ACTION_W-1:0]  s_axis_tuser,   // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [POINT_W-1:0]   m_axis_tdata,   // out_x, out_y
  output logic [2:0]           m_axis_tuser,   // has_point, status
  output logic                 m_axis_tlast    // last_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_LOAD  = 3'b100
  } state_e;

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     iter_q, iter_d;
  logic              fwd_q, fwd_d;
  logic              load_last_q, load_last_d;

  logic              out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_x_q, out_x_d;
  logic [COORD_W-1:0] out_y_q, out_y_d;
  logic              has_q, has_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic              last_q, last_d;

  logic [POINT_W-1:0] store_mem [DEPTH];
  logic [POINT_W-1:0] rd_data_q;
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;

  logic               in_xfer, out_free, is_full, is_empty;
  logic [CW-1:0]      read_off;
  action_e            action;

  assign action   = action_e'(s_axis_tuser);
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign read_off = fwd_q ? iter_q : (count_q - CW'(1) - iter_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    iter_d      = iter_q;
    fwd_d       = fwd_q;
    load_last_d = load_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    has_d       = has_q;
    status_d    = status_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_q;
    mem_raddr   = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_x_d  = '0;
          out_y_d  = '0;
          has_d    = 1'b0;
          status_d = STAT_OK;
          last_d   = 1'b1;
          case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (action == ACT_PUSH_FRONT) begin
                  head_d    = wrap_add(head_q, CW'(DEPTH - 1));
                  mem_waddr = head_d;
                end else begin
                  mem_waddr = wrap_add(head_q, count_q);
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
              end else begin
                mem_re      = 1'b1;
                count_d     = count_q - CW'(1);
                load_last_d = 1'b1;
                state_d     = ST_LOAD;
                if (action == ACT_POP_FRONT) begin
                  mem_raddr = head_q;
                  head_d    = wrap_add(head_q, CW'(1));
                end else begin
                  mem_raddr = wrap_add(head_q, count_q - CW'(1));
                end
              end
            end
            ACT_CLEAR: begin
              out_valid_d = 1'b1;
              head_d      = '0;
              count_d     = '0;
            end
            ACT_READ_FWD, ACT_READ_BWD: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
              end else begin
                iter_d  = '0;
                fwd_d   = (action == ACT_READ_FWD);
                state_d = ST_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (out_free) begin
          mem_re      = 1'b1;
          mem_raddr   = wrap_add(head_q, read_off);
          load_last_d = (iter_q == count_q - CW'(1));
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_d = 1'b1;
        out_x_d     = rd_data_q[COORD_W-1:0];
        out_y_d     = rd_data_q[POINT_W-1:COORD_W];
        has_d       = 1'b1;
        status_d    = STAT_OK;
        last_d      = load_last_q;
        if (load_last_q) begin
          state_d = ST_IDLE;
        end else begin
          iter_d  = iter_q + CW'(1);
          state_d = ST_ISSUE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      iter_q      <= '0;
      fwd_q       <= 1'b1;
      load_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      iter_q      <= iter_d;
      fwd_q       <= fwd_d;
      load_last_q <= load_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    has_q    <= has_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= s_axis_tdata;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = {status_q, has_q};
  assign m_axis_tlast  = last_q;

endmodule

FILE: sv/point_deque_chk.sv
// ----------------------------------------------------------------------------
// Point deque checker
// Port-level properties of the deque core, attached to it by a bind.
// ----------------------------------------------------------------------------
module point_deque_chk
  import pdq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [POINT_W-1:0]  m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("Stalled result changed before its transfer.");

  a_point_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == STAT_OK))
    else $error("A result with a point carries a failure status.");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:1] != STAT_OK)) |->
      (m_axis_tlast && !m_axis_tuser[0]))
    else $error("A failure result is not a single final result.");

  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("A result without a point has nonzero coordinates.");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("Input taken while the output register is blocked.");

endmodule

bind point_deque_core point_deque_chk u_point_deque_chk (.*);

FILE: dv/tb_point_deque_core.sv
// ----------------------------------------------------------------------------
// Point deque core testbench
// Runs directed and random push, pop, clear and read transfers through the
// deque core under random stalls on both streams. Every output transfer is
// checked against a ring buffer model of the deque held in the testbench.
// ----------------------------------------------------------------------------
module tb_point_deque_core;
  import pdq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int ITEM_TARGET      = 430;
  localparam int HOLD_AT          = 60;
  localparam int RECV_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                has;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    int                  mode;
    bit                  wait_empty;
  } deque_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [POINT_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [POINT_W-1:0]  m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  point_deque_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  deque_cmd_t    pending_cmds[$];
  deque_result_t exp_results[$];
  deque_cmd_t    cur_cmd;

  logic [POINT_W-1:0] ring[PDQ_DEPTH];
  logic [5:0]         front_idx = '0;
  logic [6:0]         fill_cnt = '0;

  bit gen_wait_next = 1'b0;
  int gen_mode = 0;
  int gen_count = 0;
  bit in_taken = 1'b0;
  int cur_mode = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_in = 0;
  int n_results = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_ignored = 0;

  function automatic int send_idle_pct(input int mode);
    return (mode == 0) ? 23 : (mode == 1) ? 83 : 0;
  endfunction

  function automatic int recv_idle_pct(input int mode);
    return (mode == 0) ? 83 : (mode == 1) ? 23 : 0;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_cmd(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] px,
                         input logic [COORD_W-1:0] py);
    deque_cmd_t c;
    c.act = act;
    c.px = px;
    c.py = py;
    c.mode = gen_mode;
    c.wait_empty = gen_wait_next;
    gen_wait_next = 1'b0;
    pending_cmds.push_back(c);
    if (act != ACT_UNUSED) gen_count++;
  endtask

  task automatic add_random_mix(input int upto);
    int r;
    logic [ACTION_W-1:0] act;
    while (gen_count < upto) begin
      r = $urandom_range(99);
      if (r < 22) act = ACT_PUSH_FRONT;
      else if (r < 44) act = ACT_PUSH_BACK;
      else if (r < 60) act = ACT_POP_FRONT;
      else if (r < 76) act = ACT_POP_BACK;
      else if (r < 79) act = ACT_CLEAR;
      else if (r < 88) act = ACT_READ_FWD;
      else if (r < 97) act = ACT_READ_BWD;
      else act = ACT_UNUSED;
      add_cmd(act, rand_coord(), rand_coord());
    end
  endtask

  task automatic predict_deque(input logic [ACTION_W-1:0] act, input logic [POINT_W-1:0] pt);
    deque_result_t r;
    logic [5:0] slot;
    int i;
    r = '0;
    r.last = 1'b1;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_cnt == PDQ_DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            front_idx = front_idx - 6'd1;
            slot = front_idx;
          end else begin
            slot = front_idx + fill_cnt[5:0];
          end
          ring[slot] = pt;
          fill_cnt++;
        end
        exp_results.push_back(r);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_cnt == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          if (act == ACT_POP_FRONT) begin
            slot = front_idx;
            front_idx = front_idx + 6'd1;
          end else begin
            slot = front_idx + fill_cnt[5:0] - 6'd1;
          end
          fill_cnt--;
          r.x = ring[slot][COORD_W-1:0];
          r.y = ring[slot][POINT_W-1:COORD_W];
          r.has = 1'b1;
        end
        exp_results.push_back(r);
      end
      ACT_CLEAR: begin
        front_idx = '0;
        fill_cnt = '0;
        exp_results.push_back(r);
      end
      ACT_READ_FWD, ACT_READ_BWD: begin
        if (fill_cnt == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
          exp_results.push_back(r);
        end else begin
          for (i = 0; i < fill_cnt; i++) begin
            if (act == ACT_READ_FWD) slot = front_idx + i[5:0];
            else slot = front_idx + fill_cnt[5:0] - 6'd1 - i[5:0];
            r.x = ring[slot][COORD_W-1:0];
            r.y = ring[slot][POINT_W-1:COORD_W];
            r.has = 1'b1;
            r.last = (i + 1 == fill_cnt);
            exp_results.push_back(r);
          end
        end
      end
      default: n_ignored++;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pending_cmds.size() != 0 &&
          !(pending_cmds[0].wait_empty && exp_results.size() != 0) &&
          $urandom_range(99) >= send_idle_pct(pending_cmds[0].mode)) begin
        cur_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cur_cmd.py, cur_cmd.px};
        s_axis_tuser <= cur_cmd.act;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= {$urandom(), $urandom()};
        s_axis_tuser <= 3'($urandom());
      end
    end
  end

  always @(negedge clk_i) begin
    if (!hold_done && n_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = RECV_HOLD_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(cur_mode));
    end
  end

  always @(posedge clk_i) begin
    deque_result_t got;
    deque_result_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_deque(s_axis_tuser, s_axis_tdata);
        in_taken = 1'b1;
        cur_mode = cur_cmd.mode;
        n_in++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[COORD_W-1:0];
        got.y = m_axis_tdata[POINT_W-1:COORD_W];
        got.has = m_axis_tuser[0];
        got.status = m_axis_tuser[2:1];
        got.last = m_axis_tlast;
        n_results++;
        idle_cycles = 0;
        if (exp_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result x=%h y=%h has=%b status=%0d last=%b",
                   $time, got.x, got.y, got.has, got.status, got.last);
        end else begin
          want = exp_results.pop_front();
          if (got !== want) begin
            n_errors++;
            $display("%0t: mismatch expected x=%h y=%h has=%b status=%0d last=%b",
                     $time, want.x, want.y, want.has, want.status, want.last);
            $display("%0t: mismatch actual   x=%h y=%h has=%b status=%0d last=%b",
                     $time, got.x, got.y, got.has, got.status, got.last);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, exp_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int k;
    add_cmd(ACT_READ_FWD, rand_coord(), rand_coord());
    add_cmd(ACT_READ_BWD, rand_coord(), rand_coord());
    add_cmd(ACT_POP_FRONT, rand_coord(), rand_coord());
    add_cmd(ACT_POP_BACK, rand_coord(), rand_coord());
    add_cmd(ACT_PUSH_BACK, 32'h7fff_ffff, 32'h8000_0000);
    add_cmd(ACT_PUSH_FRONT, 32'h8000_0000, 32'h7fff_ffff);
    add_cmd(ACT_PUSH_BACK, 32'h0000_0000, 32'hffff_ffff);
    add_cmd(ACT_PUSH_FRONT, 32'hffff_ffff, 32'h0000_0000);
    add_cmd(ACT_PUSH_BACK, 32'h5555_5555, 32'haaaa_aaaa);
    add_cmd(ACT_PUSH_FRONT, 32'haaaa_aaaa, 32'h5555_5555);
    add_cmd(ACT_READ_FWD, rand_coord(), rand_coord());
    add_cmd(ACT_READ_BWD, rand_coord(), rand_coord());
    add_cmd(ACT_POP_FRONT, rand_coord(), rand_coord());
    add_cmd(ACT_POP_BACK, rand_coord(), rand_coord());
    add_cmd(ACT_UNUSED, rand_coord(), rand_coord());
    add_cmd(ACT_READ_FWD, rand_coord(), rand_coord());
    add_cmd(ACT_CLEAR, rand_coord(), rand_coord());
    add_cmd(ACT_READ_BWD, rand_coord(), rand_coord());
    add_cmd(ACT_POP_FRONT, rand_coord(), rand_coord());
    add_random_mix(150);

    gen_mode = 1;
    gen_wait_next = 1'b1;
    add_random_mix(290);

    gen_mode = 2;
    gen_wait_next = 1'b1;
    add_cmd(ACT_CLEAR, rand_coord(), rand_coord());
    for (k = 0; k < PDQ_DEPTH + 2; k++) begin
      add_cmd($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, rand_coord(), rand_coord());
    end
    add_cmd(ACT_READ_FWD, rand_coord(), rand_coord());
    add_cmd(ACT_READ_BWD, rand_coord(), rand_coord());
    for (k = 0; k < PDQ_DEPTH + 2; k++) begin
      add_cmd($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, rand_coord(), rand_coord());
    end
    add_random_mix(ITEM_TARGET);

    repeat (5) @(posedge clk_i);
    #5 rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d input transfers (%0d unused code), %0d results checked",
             n_in, n_ignored, n_results);
    $display("summary: %0d refused pushes, %0d empty results, %0d errors",
             n_full, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
